// ===== rtl/core/paren_balance_remover_core_defines.svh =====
// Assertion macros used by the parenthesis balancer datapath.
`ifndef PAREN_BALANCE_REMOVER_CORE_DEFINES_SVH
`define PAREN_BALANCE_REMOVER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while arst_n is low.
`define PBR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, disabled while arst_n is low.
`define PBR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/pbr_pkg.sv =====
// Package with codes, states and control structs of the parenthesis balancer.
`default_nettype none
package pbr_pkg;

	localparam logic [7:0] OPEN_CODE  = 8'h28;
	localparam logic [7:0] CLOSE_CODE = 8'h29;

	typedef enum logic [1:0] {
		S_ACCEPT,
		S_CLEAN,
		S_SCAN,
		S_FLUSH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic absorb;
		logic pop;
		logic scan;
		logic flush;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic stack_empty;
		logic pop_pend;
		logic scan_done;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

// ===== rtl/core/pbr_in_if.sv =====
// Input channel interface: one string byte per request.
`default_nettype none
interface pbr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pbr_out_if.sv =====
// Result channel interface: one kept byte per request.
`default_nettype none
interface pbr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       out_valid;
	logic       out_last;
	logic       overflow;

	modport source (output valid, output out_char, output out_valid, output out_last,
		output overflow, input ready);
	modport sink   (input valid, input out_char, input out_valid, input out_last,
		input overflow, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pbr_ctrl.sv =====
// Controller state machine of the parenthesis balancer.
`default_nettype none
module pbr_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid,
	input  wire logic            last_char,
	output logic                 ready,
	input  wire pbr_pkg::status_t sts,
	output pbr_pkg::cmd_t        cmd
);
	import pbr_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACCEPT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_ACCEPT: begin
				if (valid && last_char) state_d = S_CLEAN;
			end
			S_CLEAN: begin
				if (sts.stack_empty && !sts.pop_pend) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (sts.scan_done) state_d = S_FLUSH;
			end
			S_FLUSH: begin
				if (sts.out_free) state_d = S_ACCEPT;
			end
			default: state_d = S_ACCEPT;
		endcase
	end

	always_comb begin
		ready      = 1'b0;
		cmd        = '0;
		unique case (state_q)
			S_ACCEPT: begin
				ready      = 1'b1;
				cmd.absorb = valid;
			end
			S_CLEAN: begin
				cmd.pop = !sts.stack_empty;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
			end
			S_FLUSH: begin
				cmd.flush = sts.out_free;
			end
			default: begin
				ready = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/pbr_dp.sv =====
// Datapath of the parenthesis balancer: buffers, open stack and result stages.
`default_nettype none
`include "paren_balance_remover_core_defines.svh"
module pbr_dp #(
	parameter int MAX_LEN = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pbr_pkg::cmd_t    cmd,
	output pbr_pkg::status_t      sts,
	input  wire logic [7:0]       char_code,
	input  wire logic             item_ready,
	output logic                  item_valid,
	output logic [7:0]            out_char,
	output logic                  out_valid,
	output logic                  out_last,
	output logic                  overflow
);
	import pbr_pkg::*;

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW = $clog2(MAX_LEN + 1);

	logic [7:0]    char_mem  [MAX_LEN];
	logic          keep_mem  [MAX_LEN];
	logic [AW-1:0] stack_mem [MAX_LEN];

	logic [CW-1:0] count_q;
	logic [CW-1:0] depth_q;
	logic [CW-1:0] idx_q;
	logic          ovf_q;

	logic          pend_s1;
	logic [AW-1:0] stack_rd_s1;

	logic          vld_s1;
	logic [7:0]    chr_s1;
	logic          keep_s1;

	logic          held_vld_q;
	logic [7:0]    held_chr_q;

	logic          out_vld_q;
	logic [7:0]    out_chr_q;
	logic          out_ok_q;
	logic          out_last_q;
	logic          out_ovf_q;

	logic          full;
	logic          store;
	logic          is_open;
	logic          is_close;
	logic          push;
	logic          pop_close;
	logic          keep_new;
	logic [CW-1:0] depth_dec;
	logic [AW-1:0] pos;
	logic          out_free;
	logic          rd_en;
	logic          s1_take;
	logic          out_load;

	assign full      = (count_q == CW'(MAX_LEN));
	assign store     = cmd.absorb && !full;
	assign is_open   = (char_code == OPEN_CODE);
	assign is_close  = (char_code == CLOSE_CODE);
	assign push      = store && is_open && (depth_q != CW'(MAX_LEN));
	assign pop_close = store && is_close && (depth_q != '0);
	assign keep_new  = !(is_close && (depth_q == '0));
	assign depth_dec = depth_q - CW'(1);
	assign pos       = count_q[AW-1:0];

	assign out_free = !out_vld_q || item_ready;
	assign s1_take  = vld_s1 && (!keep_s1 || !held_vld_q || out_free);
	assign rd_en    = cmd.scan && (idx_q != count_q) && (!vld_s1 || s1_take);
	assign out_load = (s1_take && keep_s1 && held_vld_q) || cmd.flush;

	// Memory writes.
	always_ff @(posedge clk) begin
		if (store) begin
			char_mem[pos] <= char_code;
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			keep_mem[pos] <= keep_new;
		end else if (pend_s1) begin
			keep_mem[stack_rd_s1] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			stack_mem[depth_q[AW-1:0]] <= pos;
		end
	end

	// Registered memory reads.
	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			stack_rd_s1 <= stack_mem[depth_dec[AW-1:0]];
		end
		if (rd_en) begin
			chr_s1  <= char_mem[idx_q[AW-1:0]];
			keep_s1 <= keep_mem[idx_q[AW-1:0]];
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			depth_q    <= '0;
			idx_q      <= '0;
			ovf_q      <= 1'b0;
			pend_s1    <= 1'b0;
			vld_s1     <= 1'b0;
			held_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			pend_s1 <= cmd.pop;
			if (cmd.flush) begin
				count_q <= '0;
				depth_q <= '0;
				idx_q   <= '0;
				ovf_q   <= 1'b0;
			end else begin
				if (store) count_q <= count_q + CW'(1);
				if (cmd.absorb && full) ovf_q <= 1'b1;
				if (push) begin
					depth_q <= depth_q + CW'(1);
				end else if (pop_close || cmd.pop) begin
					depth_q <= depth_dec;
				end
				if (rd_en) idx_q <= idx_q + CW'(1);
			end

			if (rd_en) begin
				vld_s1 <= 1'b1;
			end else if (s1_take) begin
				vld_s1 <= 1'b0;
			end

			if (cmd.flush) begin
				held_vld_q <= 1'b0;
			end else if (s1_take && keep_s1) begin
				held_vld_q <= 1'b1;
			end

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (item_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s1_take && keep_s1) begin
			held_chr_q <= chr_s1;
		end
		if (cmd.flush) begin
			out_chr_q  <= held_vld_q ? held_chr_q : 8'h00;
			out_ok_q   <= held_vld_q;
			out_last_q <= 1'b1;
			out_ovf_q  <= ovf_q;
		end else if (out_load) begin
			out_chr_q  <= held_chr_q;
			out_ok_q   <= 1'b1;
			out_last_q <= 1'b0;
			out_ovf_q  <= ovf_q;
		end
	end

	assign sts.stack_empty = (depth_q == '0);
	assign sts.pop_pend    = pend_s1;
	assign sts.scan_done   = (idx_q == count_q) && !vld_s1;
	assign sts.out_free    = out_free;

	assign item_valid = out_vld_q;
	assign out_char   = out_chr_q;
	assign out_valid  = out_ok_q;
	assign out_last   = out_last_q;
	assign overflow   = out_ovf_q;

	`PBR_ASSERT_NOW(a_depth_le_count, 1'b1, depth_q <= count_q, "stack deeper than string")
	`PBR_ASSERT_NOW(a_load_free, out_load, out_free, "result register overwritten")
	`PBR_ASSERT_NOW(a_clean_no_absorb, pend_s1, !cmd.absorb, "clean-up write meets new byte")
	`PBR_ASSERT_NEXT(a_flush_scan_done, cmd.flush && !item_ready, out_vld_q && out_last_q,
		"final result not held")

endmodule
`default_nettype wire

// ===== rtl/core/paren_balance_remover_core.sv =====
// Top level of the parenthesis balancer: controller and datapath joined.
// Usage:
//   The block takes a string on the text channel, one byte per request, with
//   last_char set on the final byte. It drops every ')' that has no matching
//   '(' and every '(' left unmatched at the end, and sends the remaining bytes
//   in order on the result channel, with out_last set on the final one.
//   An empty result is sent as one request with out_valid low and out_last high.
//   Strings longer than MAX_LEN bytes are cut: the extra bytes are dropped and
//   overflow is high on every result request of that string.
// Sequence:
//   Each byte is taken as soon as it is offered. After the final byte the
//   clean-up pass pops the open stack, one unmatched open at a time; the
//   buffer is then scanned one entry per cycle through its single read port,
//   except while the receiver holds back a full result register, and the
//   final request is then loaded. The text channel is not ready from
//   clean-up until that request is loaded, which waits for a free result slot.
// Reset and stalls:
//   arst_n clears the counters, the stack depth and the handshake valid flags;
//   stored bytes need no clearing. When the receiver stalls, the scan stops and
//   every result is held in its register; nothing is lost or repeated.
`default_nettype none
module paren_balance_remover_core #(
	parameter int MAX_LEN = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pbr_in_if.sink    text,
	pbr_out_if.source result
);
	import pbr_pkg::*;

	cmd_t    cmd;
	status_t sts;

	// The controller sequences absorb, clean-up, scan and final flush.
	pbr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (text.valid),
		.last_char (text.last_char),
		.ready     (text.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the buffers, the open stack and the result stages.
	pbr_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.char_code  (text.char_code),
		.item_ready (result.ready),
		.item_valid (result.valid),
		.out_char   (result.out_char),
		.out_valid  (result.out_valid),
		.out_last   (result.out_last),
		.overflow   (result.overflow)
	);

endmodule
`default_nettype wire
